[sv/assert_macros.svh]
// assertion macros shared by the allocator rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/nfa_pkg.sv]
`timescale 1ns / 1ps
// types and constants of the next-fit boundary tag allocator
// no dependencies; used by nfa_ctrl, nfa_dp and the top level
package nfa_pkg;

  localparam int unsigned WSIZE        = 4;
  localparam int unsigned DSIZE        = 8;
  localparam int unsigned MIN_BLOCK    = 2 * DSIZE;
  localparam int unsigned HEAP_START   = 8;
  localparam int unsigned PROLOGUE_TAG = DSIZE + 1;
  localparam int unsigned EPILOGUE_TAG = 1;
  localparam int unsigned CHUNK_W      = 17;
  localparam int unsigned SIZE_W       = 16;
  localparam int unsigned ADDR_W       = 16;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT,
    OP_INIT0, OP_INIT1, OP_INIT2, OP_INIT3,
    OP_GROW0, OP_GROW1, OP_GROW2, OP_UNREADY,
    OP_MRG0, OP_MRG1, OP_MRG2, OP_MRG3, OP_MRG4,
    OP_INITOK, OP_ALLOC0, OP_STEP, OP_WRAP, OP_FOUND, OP_MISS,
    OP_CARVE0, OP_CARVE1, OP_CARVE2, OP_CARVE3,
    OP_FREEW0, OP_FREEW1, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e stat;
    logic    use_bp;
  } cmd_t;

  typedef struct packed {
    cmd_code_e cmd;
    logic      ready;
    logic      size_zero;
    logic      tag_zero;
    logic      fit;
    logic      tag_alloc;
    logic      bp_lt_rover;
    logic      bp_gt_addr;
    logic      bp_eq_addr;
    logic      grow_ok;
    logic      merge_wr;
    logic      split;
    logic      out_free;
  } sts_t;

endpackage

[sv/nfa_ctrl.sv]
`timescale 1ns / 1ps
// sequencer of the allocator: walks each request through datapath micro-ops
// depends on nfa_pkg and assert_macros.svh
`include "assert_macros.svh"
module nfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output nfa_pkg::cmd_t cmd_o,
  input  nfa_pkg::sts_t sts_i
);

  typedef enum logic [25:0] {
    S_IDLE     = 26'b1 << 0,
    S_DISPATCH = 26'b1 << 1,
    S_INIT1    = 26'b1 << 2,
    S_INIT2    = 26'b1 << 3,
    S_INIT3    = 26'b1 << 4,
    S_A_HDR    = 26'b1 << 5,
    S_A_SCAN   = 26'b1 << 6,
    S_W_HDR    = 26'b1 << 7,
    S_W_SCAN   = 26'b1 << 8,
    S_GROW0    = 26'b1 << 9,
    S_GROW1    = 26'b1 << 10,
    S_GROW2    = 26'b1 << 11,
    S_MRG0     = 26'b1 << 12,
    S_MRG1     = 26'b1 << 13,
    S_MRG2     = 26'b1 << 14,
    S_MRG3     = 26'b1 << 15,
    S_MRG4     = 26'b1 << 16,
    S_MEND     = 26'b1 << 17,
    S_CARVE0   = 26'b1 << 18,
    S_CARVE1   = 26'b1 << 19,
    S_CARVE2   = 26'b1 << 20,
    S_CARVE3   = 26'b1 << 21,
    S_F_HDR    = 26'b1 << 22,
    S_F_SCAN   = 26'b1 << 23,
    S_FREEW1   = 26'b1 << 24,
    S_DONE     = 26'b1 << 25
  } state_e;

  state_e           state_q, state_d;
  nfa_pkg::status_e done_stat_q, done_stat_d;
  logic             done_bp_q, done_bp_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    done_stat_d = done_stat_q;
    done_bp_d   = done_bp_q;
    cmd_o.op     = nfa_pkg::OP_NONE;
    cmd_o.stat   = done_stat_q;
    cmd_o.use_bp = done_bp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = nfa_pkg::OP_ACCEPT;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          nfa_pkg::CMD_INIT: begin
            cmd_o.op = nfa_pkg::OP_INIT0;
            state_d  = S_INIT1;
          end
          nfa_pkg::CMD_ALLOC: begin
            if (!sts_i.ready) begin
              done_stat_d = nfa_pkg::ST_NOT_READY;
              done_bp_d   = 1'b0;
              state_d     = S_DONE;
            end else if (sts_i.size_zero) begin
              done_stat_d = nfa_pkg::ST_ZERO_SIZE;
              done_bp_d   = 1'b0;
              state_d     = S_DONE;
            end else begin
              cmd_o.op = nfa_pkg::OP_ALLOC0;
              state_d  = S_A_HDR;
            end
          end
          nfa_pkg::CMD_FREE: begin
            if (!sts_i.ready) begin
              done_stat_d = nfa_pkg::ST_NOT_READY;
              done_bp_d   = 1'b0;
              state_d     = S_DONE;
            end else begin
              cmd_o.op = nfa_pkg::OP_WRAP;
              state_d  = S_F_HDR;
            end
          end
          default: begin
            done_stat_d = nfa_pkg::ST_OK;
            done_bp_d   = 1'b0;
            state_d     = S_DONE;
          end
        endcase
      end
      S_INIT1: begin
        cmd_o.op = nfa_pkg::OP_INIT1;
        state_d  = S_INIT2;
      end
      S_INIT2: begin
        cmd_o.op = nfa_pkg::OP_INIT2;
        state_d  = S_INIT3;
      end
      S_INIT3: begin
        cmd_o.op = nfa_pkg::OP_INIT3;
        state_d  = S_GROW0;
      end
      S_A_HDR: begin
        cmd_o.op = nfa_pkg::OP_STEP;
        state_d  = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (sts_i.tag_zero) begin
          cmd_o.op = nfa_pkg::OP_WRAP;
          state_d  = S_W_HDR;
        end else if (sts_i.fit) begin
          cmd_o.op = nfa_pkg::OP_FOUND;
          state_d  = S_CARVE0;
        end else begin
          cmd_o.op = nfa_pkg::OP_STEP;
        end
      end
      S_W_HDR: begin
        if (!sts_i.bp_lt_rover || sts_i.tag_zero) begin
          cmd_o.op = nfa_pkg::OP_MISS;
          state_d  = S_GROW0;
        end else begin
          cmd_o.op = nfa_pkg::OP_STEP;
          state_d  = S_W_SCAN;
        end
      end
      S_W_SCAN: begin
        if (sts_i.fit) begin
          cmd_o.op = nfa_pkg::OP_FOUND;
          state_d  = S_CARVE0;
        end else if (sts_i.bp_lt_rover && !sts_i.tag_zero) begin
          cmd_o.op = nfa_pkg::OP_STEP;
        end else begin
          cmd_o.op = nfa_pkg::OP_MISS;
          state_d  = S_GROW0;
        end
      end
      S_GROW0: begin
        if (sts_i.grow_ok) begin
          cmd_o.op = nfa_pkg::OP_GROW0;
          state_d  = S_GROW1;
        end else begin
          if (sts_i.cmd == nfa_pkg::CMD_INIT) cmd_o.op = nfa_pkg::OP_UNREADY;
          done_stat_d = nfa_pkg::ST_NO_MEM;
          done_bp_d   = 1'b0;
          state_d     = S_DONE;
        end
      end
      S_GROW1: begin
        cmd_o.op = nfa_pkg::OP_GROW1;
        state_d  = S_GROW2;
      end
      S_GROW2: begin
        cmd_o.op = nfa_pkg::OP_GROW2;
        state_d  = S_MRG0;
      end
      S_MRG0: begin
        cmd_o.op = nfa_pkg::OP_MRG0;
        state_d  = S_MRG1;
      end
      S_MRG1: begin
        cmd_o.op = nfa_pkg::OP_MRG1;
        state_d  = S_MRG2;
      end
      S_MRG2: begin
        cmd_o.op = nfa_pkg::OP_MRG2;
        state_d  = sts_i.merge_wr ? S_MRG3 : S_MEND;
      end
      S_MRG3: begin
        cmd_o.op = nfa_pkg::OP_MRG3;
        state_d  = S_MRG4;
      end
      S_MRG4: begin
        cmd_o.op = nfa_pkg::OP_MRG4;
        state_d  = S_MEND;
      end
      S_MEND: begin
        case (sts_i.cmd)
          nfa_pkg::CMD_INIT: begin
            cmd_o.op    = nfa_pkg::OP_INITOK;
            done_stat_d = nfa_pkg::ST_OK;
            done_bp_d   = 1'b0;
            state_d     = S_DONE;
          end
          nfa_pkg::CMD_ALLOC: begin
            cmd_o.op = nfa_pkg::OP_CARVE0;
            state_d  = S_CARVE1;
          end
          default: begin
            done_stat_d = nfa_pkg::ST_OK;
            done_bp_d   = 1'b0;
            state_d     = S_DONE;
          end
        endcase
      end
      S_CARVE0: begin
        cmd_o.op = nfa_pkg::OP_CARVE0;
        state_d  = S_CARVE1;
      end
      S_CARVE1: begin
        cmd_o.op = nfa_pkg::OP_CARVE1;
        if (sts_i.split) begin
          state_d = S_CARVE2;
        end else begin
          done_stat_d = nfa_pkg::ST_OK;
          done_bp_d   = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_CARVE2: begin
        cmd_o.op = nfa_pkg::OP_CARVE2;
        state_d  = S_CARVE3;
      end
      S_CARVE3: begin
        cmd_o.op    = nfa_pkg::OP_CARVE3;
        done_stat_d = nfa_pkg::ST_OK;
        done_bp_d   = 1'b1;
        state_d     = S_DONE;
      end
      S_F_HDR: begin
        cmd_o.op = nfa_pkg::OP_STEP;
        state_d  = S_F_SCAN;
      end
      S_F_SCAN: begin
        if (sts_i.tag_zero || sts_i.bp_gt_addr || (sts_i.bp_eq_addr && !sts_i.tag_alloc)) begin
          done_stat_d = nfa_pkg::ST_OK;
          done_bp_d   = 1'b0;
          state_d     = S_DONE;
        end else if (sts_i.bp_eq_addr) begin
          cmd_o.op = nfa_pkg::OP_FREEW0;
          state_d  = S_FREEW1;
        end else begin
          cmd_o.op = nfa_pkg::OP_STEP;
        end
      end
      S_FREEW1: begin
        cmd_o.op = nfa_pkg::OP_FREEW1;
        state_d  = S_MRG0;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = nfa_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_stat_q <= nfa_pkg::ST_OK;
      done_bp_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_stat_q <= done_stat_d;
      done_bp_q   <= done_bp_d;
    end
  end

  `ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DISPATCH)
  `ASSERT_ALWAYS(a_out_only_done, clk_i, rst_ni, (cmd_o.op != nfa_pkg::OP_OUT) || (state_q == S_DONE))
  `ASSERT_NEXT(a_done_leaves, clk_i, rst_ni, state_q == S_DONE && sts_i.out_free, state_q == S_IDLE)

endmodule

[sv/nfa_dp.sv]
`timescale 1ns / 1ps
// datapath of the allocator: arena memory, heap registers, tag arithmetic
// depends on nfa_pkg and assert_macros.svh
`include "assert_macros.svh"
module nfa_dp #(
  parameter int unsigned ARENA_WORDS = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [nfa_pkg::CHUNK_W-1:0]   cfg_data_i,
  input  logic [1:0]                    command_i,
  input  logic [nfa_pkg::SIZE_W-1:0]    size_bytes_i,
  input  logic [nfa_pkg::ADDR_W-1:0]    block_address_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [nfa_pkg::ADDR_W-1:0]    result_address_o,
  output logic [1:0]                    status_o,
  input  nfa_pkg::cmd_t                 cmd_i,
  output nfa_pkg::sts_t                 sts_o
);

  localparam int WIW   = $clog2(ARENA_WORDS);
  localparam int ByteW = WIW + 3;
  localparam int OW    = (ByteW > 18) ? ByteW : 18;
  localparam logic [OW-1:0] Limit   = OW'(ARENA_WORDS) << 2;
  localparam logic [OW-1:0] Wsz     = OW'(nfa_pkg::WSIZE);
  localparam logic [OW-1:0] Dsz     = OW'(nfa_pkg::DSIZE);
  localparam logic [OW-1:0] MinBlk  = OW'(nfa_pkg::MIN_BLOCK);
  localparam logic [OW-1:0] HeapSt  = OW'(nfa_pkg::HEAP_START);
  localparam logic [OW-1:0] FirstBrk = OW'(2 * nfa_pkg::DSIZE);

  function automatic logic [31:0] tag_word(logic [OW-1:0] sz, logic al);
    tag_word = {{(32 - OW){1'b0}}, sz} | {31'd0, al};
  endfunction

  logic [31:0] mem [ARENA_WORDS];

  logic [nfa_pkg::CHUNK_W-1:0] chunk_q;
  logic [OW-1:0]               brk_q, rover_q;
  logic                        ready_q;
  logic                        out_valid_q;
  nfa_pkg::cmd_code_e          cmd_q;
  logic [nfa_pkg::SIZE_W-1:0]  size_q;
  logic [nfa_pkg::ADDR_W-1:0]  addr_q;
  logic [OW-1:0]               bp_q, sz_q, asize_q, gsz_q, ptag_q;
  logic                        split_q;
  logic [nfa_pkg::ADDR_W-1:0]  res_q;
  logic [1:0]                  stat_q;
  logic [31:0]                 rd_raw_q;
  logic                        rd_oob_q;

  logic        rd_en, wr_en, rd_in, wr_in;
  logic [OW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data, rdata;

  logic [17:0]   chunk_rnd, chunk_eff;
  logic [16:0]   asize_calc;
  logic [OW-1:0] tag_sz, step_bp, carve_rem, carve_sz, psz, mrg_sz, mrg_bp;
  logic          tag_al, split_now, grow_ok;

  // read data, out-of-arena words read as zero
  assign rdata  = rd_oob_q ? 32'd0 : rd_raw_q;
  assign tag_sz = {rdata[OW-1:3], 3'b000};
  assign tag_al = rdata[0];

  assign chunk_rnd = ({1'b0, chunk_q} + 18'd7) & ~18'd7;
  assign chunk_eff = (chunk_rnd < 18'(nfa_pkg::MIN_BLOCK)) ? 18'(nfa_pkg::MIN_BLOCK)
                                                            : chunk_rnd;
  assign asize_calc = (size_q <= 16'(nfa_pkg::DSIZE)) ? 17'(nfa_pkg::MIN_BLOCK)
                                                      : (({1'b0, size_q} + 17'd15) & ~17'd7);

  assign step_bp   = bp_q + tag_sz;
  assign carve_rem = sz_q - asize_q;
  assign split_now = (carve_rem >= MinBlk);
  assign carve_sz  = split_q ? asize_q : sz_q;

  // coalesce with the previous footer and the next header
  assign psz    = {ptag_q[OW-1:3], 3'b000};
  assign mrg_sz = sz_q + (tag_al ? '0 : tag_sz) + (ptag_q[0] ? '0 : psz);
  assign mrg_bp = ptag_q[0] ? bp_q : (bp_q - psz);

  assign grow_ok = (brk_q <= Limit) && (gsz_q <= (Limit - brk_q));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (cmd_i.op)
      nfa_pkg::OP_INIT0: begin
        wr_en = 1'b1; wr_addr = '0; wr_data = '0;
      end
      nfa_pkg::OP_INIT1: begin
        wr_en = 1'b1; wr_addr = Wsz; wr_data = 32'(nfa_pkg::PROLOGUE_TAG);
      end
      nfa_pkg::OP_INIT2: begin
        wr_en = 1'b1; wr_addr = Dsz; wr_data = 32'(nfa_pkg::PROLOGUE_TAG);
      end
      nfa_pkg::OP_INIT3: begin
        wr_en = 1'b1; wr_addr = Dsz + Wsz; wr_data = 32'(nfa_pkg::EPILOGUE_TAG);
      end
      nfa_pkg::OP_GROW0: begin
        wr_en = 1'b1; wr_addr = brk_q - Wsz; wr_data = tag_word(gsz_q, 1'b0);
      end
      nfa_pkg::OP_GROW1: begin
        wr_en = 1'b1; wr_addr = bp_q + sz_q - Dsz; wr_data = tag_word(sz_q, 1'b0);
      end
      nfa_pkg::OP_GROW2: begin
        wr_en = 1'b1; wr_addr = bp_q + sz_q - Wsz; wr_data = 32'(nfa_pkg::EPILOGUE_TAG);
      end
      nfa_pkg::OP_MRG0: begin
        rd_en = 1'b1; rd_addr = bp_q - Dsz;
      end
      nfa_pkg::OP_MRG1: begin
        rd_en = 1'b1; rd_addr = bp_q + sz_q - Wsz;
      end
      nfa_pkg::OP_MRG3: begin
        wr_en = 1'b1; wr_addr = bp_q - Wsz; wr_data = tag_word(sz_q, 1'b0);
      end
      nfa_pkg::OP_MRG4: begin
        wr_en = 1'b1; wr_addr = bp_q + sz_q - Dsz; wr_data = tag_word(sz_q, 1'b0);
      end
      nfa_pkg::OP_ALLOC0: begin
        rd_en = 1'b1; rd_addr = rover_q - Wsz;
      end
      nfa_pkg::OP_STEP: begin
        rd_en = 1'b1; rd_addr = step_bp - Wsz;
      end
      nfa_pkg::OP_WRAP: begin
        rd_en = 1'b1; rd_addr = HeapSt - Wsz;
      end
      nfa_pkg::OP_CARVE0: begin
        wr_en   = 1'b1;
        wr_addr = bp_q - Wsz;
        wr_data = tag_word(split_now ? asize_q : sz_q, 1'b1);
      end
      nfa_pkg::OP_CARVE1: begin
        wr_en = 1'b1; wr_addr = bp_q + carve_sz - Dsz; wr_data = tag_word(carve_sz, 1'b1);
      end
      nfa_pkg::OP_CARVE2: begin
        wr_en = 1'b1; wr_addr = bp_q + asize_q - Wsz; wr_data = tag_word(carve_rem, 1'b0);
      end
      nfa_pkg::OP_CARVE3: begin
        wr_en = 1'b1; wr_addr = bp_q + sz_q - Dsz; wr_data = tag_word(carve_rem, 1'b0);
      end
      nfa_pkg::OP_FREEW0: begin
        wr_en = 1'b1; wr_addr = bp_q - Wsz; wr_data = tag_word(tag_sz, 1'b0);
      end
      nfa_pkg::OP_FREEW1: begin
        wr_en = 1'b1; wr_addr = bp_q + sz_q - Dsz; wr_data = tag_word(sz_q, 1'b0);
      end
      default: ;
    endcase
  end

  assign rd_in = (rd_addr[OW-1:2] < (OW - 2)'(ARENA_WORDS));
  assign wr_in = (wr_addr[OW-1:2] < (OW - 2)'(ARENA_WORDS));

  // single port arena, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_in) mem[wr_addr[WIW+1:2]] <= wr_data;
    if (rd_en) begin
      rd_raw_q <= mem[rd_addr[WIW+1:2]];
      rd_oob_q <= !rd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= nfa_pkg::CHUNK_RESET;
      brk_q       <= '0;
      rover_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) chunk_q <= cfg_data_i;
      if (cmd_i.op == nfa_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        nfa_pkg::OP_INIT0: begin
          brk_q   <= FirstBrk;
          rover_q <= HeapSt;
        end
        nfa_pkg::OP_GROW2:   brk_q   <= brk_q + sz_q;
        nfa_pkg::OP_MRG2:    rover_q <= mrg_bp;
        nfa_pkg::OP_UNREADY: ready_q <= 1'b0;
        nfa_pkg::OP_INITOK: begin
          rover_q <= HeapSt;
          ready_q <= 1'b1;
        end
        nfa_pkg::OP_OUT: begin
          if (cmd_i.use_bp) rover_q <= bp_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      nfa_pkg::OP_ACCEPT: begin
        cmd_q  <= nfa_pkg::cmd_code_e'(command_i);
        size_q <= size_bytes_i;
        addr_q <= block_address_i;
      end
      nfa_pkg::OP_INIT3: gsz_q <= OW'(chunk_eff);
      nfa_pkg::OP_GROW0: begin
        bp_q <= brk_q;
        sz_q <= gsz_q;
      end
      nfa_pkg::OP_MRG1: ptag_q <= rdata[OW-1:0];
      nfa_pkg::OP_MRG2: begin
        sz_q <= mrg_sz;
        bp_q <= mrg_bp;
      end
      nfa_pkg::OP_ALLOC0: begin
        asize_q <= OW'(asize_calc);
        bp_q    <= rover_q;
      end
      nfa_pkg::OP_STEP:   bp_q <= step_bp;
      nfa_pkg::OP_WRAP:   bp_q <= HeapSt;
      nfa_pkg::OP_FOUND:  sz_q <= tag_sz;
      nfa_pkg::OP_MISS:   gsz_q <= (asize_q > OW'(chunk_eff)) ? asize_q : OW'(chunk_eff);
      nfa_pkg::OP_CARVE0: split_q <= split_now;
      nfa_pkg::OP_FREEW0: sz_q <= tag_sz;
      nfa_pkg::OP_OUT: begin
        res_q  <= cmd_i.use_bp ? bp_q[nfa_pkg::ADDR_W-1:0] : '0;
        stat_q <= cmd_i.stat;
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_q;
  assign status_o         = stat_q;

  assign sts_o.cmd         = cmd_q;
  assign sts_o.ready       = ready_q;
  assign sts_o.size_zero   = (size_q == '0);
  assign sts_o.tag_zero    = (tag_sz == '0);
  assign sts_o.fit         = !tag_al && (asize_q <= tag_sz);
  assign sts_o.tag_alloc   = tag_al;
  assign sts_o.bp_lt_rover = (bp_q < rover_q);
  assign sts_o.bp_gt_addr  = (bp_q > OW'(addr_q));
  assign sts_o.bp_eq_addr  = (bp_q == OW'(addr_q));
  assign sts_o.grow_ok     = grow_ok;
  assign sts_o.merge_wr    = !(ptag_q[0] && tag_al);
  assign sts_o.split       = split_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  `ASSERT_ALWAYS(a_brk_bounds, clk_i, rst_ni, !ready_q || (brk_q >= FirstBrk && brk_q <= Limit))
  `ASSERT_ALWAYS(a_rover_in_heap, clk_i, rst_ni, !ready_q || (rover_q >= HeapSt && rover_q < brk_q))
  `ASSERT_NEXT(a_out_loaded, clk_i, rst_ni, cmd_i.op == nfa_pkg::OP_OUT, out_valid_q)

endmodule

[sv/next_fit_boundary_tag_allocator.sv]
`timescale 1ns / 1ps
// top level of the next-fit boundary tag heap allocator
// depends on nfa_pkg, nfa_ctrl, nfa_dp and assert_macros.svh
//
//  channel   direction  handshake                 payload
//  request   in         in_valid_i / in_stall_o   command_i, size_bytes_i, block_address_i
//  result    out        out_valid_o / out_stall_i result_address_o, status_o
//  config    in         cfg_valid_i / cfg_ready_o cfg_data_i (chunk_bytes)
//
// one request at a time; the single-port arena memory paces everything, one tag
// access per cycle and one block visited per cycle during a search or free walk
// allocate: walks blocks from the rover, wraps to heap start, grows the heap on a
// miss and carves the block; initialize: writes the prologue and epilogue tags
// and grows the heap; free: walks blocks from heap start to the address, then
// frees and coalesces; reset clears control state only; the arena holds nothing until an initialize
// a finished result waits in the output register while the next request is taken
`include "assert_macros.svh"
module next_fit_boundary_tag_allocator #(
  parameter int unsigned ARENA_WORDS = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [nfa_pkg::SIZE_W-1:0]  size_bytes_i,
  input  logic [nfa_pkg::ADDR_W-1:0]  block_address_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [nfa_pkg::ADDR_W-1:0]  result_address_o,
  output logic [1:0]                  status_o,
  // chunk size register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nfa_pkg::CHUNK_W-1:0] cfg_data_i
);

  nfa_pkg::cmd_t cmd;
  nfa_pkg::sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  nfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // arena, heap registers and tag arithmetic
  nfa_dp #(
    .ARENA_WORDS (ARENA_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .size_bytes_i     (size_bytes_i),
    .block_address_i  (block_address_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  // failures and non-allocating requests never return an address
  `ASSERT_ALWAYS(a_fail_no_addr, clk_i, rst_ni, !out_valid_o || status_o == nfa_pkg::ST_OK || result_address_o == '0)
  `ASSERT_ALWAYS(a_busy_stall, clk_i, rst_ni, !(cmd.op == nfa_pkg::OP_ACCEPT) || !in_stall_o)

endmodule
